// File: design/kv_value_hadamard_quantizer_macros.svh
// Assertion macros for the quantizer RTL (used by kvhq_dp).
// Needs clk and arst_n in the scope where a macro is used.
`ifndef KV_VALUE_HADAMARD_QUANTIZER_MACROS_SVH
`define KV_VALUE_HADAMARD_QUANTIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KVHQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KVHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/kvhq_pkg.sv
// Shared types, constants and helpers of the value quantizer.
// No dependencies; used by all quantizer modules except kvhq_div.
package kvhq_pkg;

	localparam int unsigned HEADS_DEF    = 4;
	localparam int unsigned HEAD_DIM_DEF = 16;
	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned CODE_W       = 4;
	localparam int unsigned SCALE_W      = 28;
	localparam int unsigned QMAX_W       = 3;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 2;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 28'd65536;
	localparam logic [SCALE_W-1:0] SCALE_SAT = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIT_PLAN = 2'd0,
		CFG_ROTATE   = 2'd1,
		CFG_QUANT    = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] PLAN_2BIT = 2'd0;
	localparam logic [1:0] PLAN_4BIT = 2'd3;

	typedef struct packed {
		logic load_wr;
		logic close;
		logic xf_rd;
		logic xf_wa;
		logic xf_wb;
		logic max_acc;
		logic scale_start;
		logic scale_take;
		logic el_start;
		logic out_load;
		logic idx_inc;
	} kvhq_cmd_t;

	typedef struct packed {
		logic row_close;
		logic quant_en;
		logic xf_en;
		logic xf_last;
		logic idx_last;
		logic div_busy;
		logic out_free;
	} kvhq_sts_t;

	function automatic logic [QMAX_W-1:0] qmax_for_plan(input logic [1:0] plan);
		logic [QMAX_W-1:0] q;
		case (plan)
			PLAN_2BIT: q = 3'd1;
			PLAN_4BIT: q = 3'd7;
			default:   q = 3'd3;
		endcase
		return q;
	endfunction

endpackage

// File: design/kvhq_div.sv
// Restoring divider, one quotient bit per cycle, shared by scale and codes.
// Depends on nothing; instantiated by kvhq_dp.
module kvhq_div #(
	parameter int unsigned DVW = 32,
	parameter int unsigned RW  = 20,
	parameter int unsigned CW  = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [RW-1:0]  rem_init,
	input  logic [DVW-1:0] bits_init,
	input  logic [RW-1:0]  divisor,
	input  logic [CW-1:0]  steps,
	output logic           busy,
	output logic [DVW-1:0] quot
);

	logic [CW-1:0]  cnt_q;
	logic [RW-1:0]  rem_q;
	logic [RW-1:0]  dsr_q;
	logic [DVW-1:0] bits_q;
	logic [DVW-1:0] quot_q;
	logic [RW-1:0]  trial;
	logic           fits;

	assign trial = {rem_q[RW-2:0], bits_q[DVW-1]};
	assign fits  = trial >= dsr_q;
	assign busy  = cnt_q != '0;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			bits_q <= bits_init;
			dsr_q  <= divisor;
			quot_q <= '0;
		end else if (busy) begin
			rem_q  <= fits ? trial - dsr_q : trial;
			bits_q <= {bits_q[DVW-2:0], 1'b0};
			quot_q <= {quot_q[DVW-2:0], fits};
		end
	end

endmodule

// File: design/kvhq_ctrl.sv
// Sequencer of the quantizer: load, transform, max search, scale, drain.
// Depends on kvhq_pkg; drives kvhq_dp through command and status structs.
module kvhq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  kvhq_pkg::kvhq_sts_t sts,
	output kvhq_pkg::kvhq_cmd_t cmd,
	output logic                in_ready
);

	typedef enum logic [11:0] {
		S_LOAD     = 12'b0000_0000_0001,
		S_XF_RD    = 12'b0000_0000_0010,
		S_XF_WA    = 12'b0000_0000_0100,
		S_XF_WB    = 12'b0000_0000_1000,
		S_MAX_RD   = 12'b0000_0001_0000,
		S_MAX_ACC  = 12'b0000_0010_0000,
		S_SCL_GO   = 12'b0000_0100_0000,
		S_SCL_WAIT = 12'b0000_1000_0000,
		S_EL_RD    = 12'b0001_0000_0000,
		S_EL_GO    = 12'b0010_0000_0000,
		S_EL_WAIT  = 12'b0100_0000_0000,
		S_EL_PUT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = state_q == S_LOAD;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (sts.row_close) begin
						cmd.close = 1'b1;
						if (!sts.quant_en) begin
							state_d = S_LOAD;
						end else if (sts.xf_en) begin
							state_d = S_XF_RD;
						end else begin
							state_d = S_MAX_RD;
						end
					end
				end
			end
			S_XF_RD: begin
				cmd.xf_rd = 1'b1;
				state_d   = S_XF_WA;
			end
			S_XF_WA: begin
				cmd.xf_wa = 1'b1;
				state_d   = S_XF_WB;
			end
			S_XF_WB: begin
				cmd.xf_wb = 1'b1;
				state_d   = sts.xf_last ? S_MAX_RD : S_XF_RD;
			end
			S_MAX_RD: begin
				state_d = S_MAX_ACC;
			end
			S_MAX_ACC: begin
				cmd.max_acc = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = sts.idx_last ? S_SCL_GO : S_MAX_RD;
			end
			S_SCL_GO: begin
				cmd.scale_start = 1'b1;
				state_d         = S_SCL_WAIT;
			end
			S_SCL_WAIT: begin
				if (!sts.div_busy) begin
					cmd.scale_take = 1'b1;
					state_d        = S_EL_RD;
				end
			end
			S_EL_RD: begin
				state_d = S_EL_GO;
			end
			S_EL_GO: begin
				cmd.el_start = 1'b1;
				state_d      = S_EL_WAIT;
			end
			S_EL_WAIT: begin
				if (!sts.div_busy) begin
					state_d = S_EL_PUT;
				end
			end
			S_EL_PUT: begin
				// hold the code until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.idx_inc  = 1'b1;
					state_d      = sts.idx_last ? S_LOAD : S_EL_RD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/kvhq_dp.sv
// Datapath: config registers, row memory, butterfly, max, divider, output register.
// Depends on kvhq_pkg, kvhq_div and the assertion macro header.
`include "kv_value_hadamard_quantizer_macros.svh"

module kvhq_dp #(
	parameter int unsigned HEADS    = kvhq_pkg::HEADS_DEF,
	parameter int unsigned HEAD_DIM = kvhq_pkg::HEAD_DIM_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  kvhq_pkg::kvhq_cmd_t                    cmd,
	output kvhq_pkg::kvhq_sts_t                    sts,
	input  logic                                   cfg_valid,
	input  logic [kvhq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [kvhq_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [kvhq_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                   row_end,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic [kvhq_pkg::CODE_W-1:0]            code,
	output logic [kvhq_pkg::SCALE_W-1:0]           row_scale,
	output logic                                   last_code
);

	localparam int unsigned ROW_LEN = HEADS * HEAD_DIM;
	localparam int unsigned LOG     = $clog2(HEAD_DIM);
	localparam bit          POW2    = (HEAD_DIM & (HEAD_DIM - 1)) == 0;
	localparam int unsigned WW      = kvhq_pkg::SAMPLE_W + LOG;
	localparam int unsigned AW      = $clog2(ROW_LEN);
	localparam int unsigned PW      = (ROW_LEN > 2) ? $clog2(ROW_LEN / 2) : 1;
	localparam int unsigned SW      = (LOG > 1) ? $clog2(LOG) : 1;
	localparam int unsigned DVW     = WW + 12;
	localparam int unsigned RW      = WW + 2;
	localparam int unsigned CW      = $clog2(DVW + 1);
	localparam int unsigned QW      = kvhq_pkg::QMAX_W;

	// configuration
	logic [1:0] bit_plan_q;
	logic       rotate_q;
	logic       quant_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_plan_q <= 2'd1;
			rotate_q   <= 1'b1;
			quant_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (kvhq_pkg::cfg_idx_t'(cfg_index))
				kvhq_pkg::CFG_BIT_PLAN: bit_plan_q <= cfg_data[1:0];
				kvhq_pkg::CFG_ROTATE:   rotate_q   <= cfg_data[0];
				kvhq_pkg::CFG_QUANT:    quant_q    <= cfg_data[0];
				default:                ;
			endcase
		end
	end

	logic [QW-1:0] qmax;
	assign qmax = kvhq_pkg::qmax_for_plan(bit_plan_q);

	// counters
	logic [AW-1:0] fill_q;
	logic [AW:0]   len_q;
	logic [PW-1:0] p_q;
	logic [SW-1:0] s_q;
	logic [AW-1:0] idx_q;
	logic          p_last;
	logic          s_last;
	logic          idx_last;
	logic          row_close;

	assign p_last    = p_q == PW'(ROW_LEN / 2 - 1);
	assign s_last    = s_q == SW'(LOG - 1);
	assign idx_last  = idx_q == AW'(ROW_LEN - 1);
	assign row_close = row_end || (fill_q == AW'(ROW_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			p_q    <= '0;
			s_q    <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.close) begin
				fill_q <= '0;
				len_q  <= {1'b0, fill_q} + 1'b1;
				p_q    <= '0;
				s_q    <= '0;
				idx_q  <= '0;
			end else if (cmd.load_wr) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.xf_wb) begin
				if (p_last) begin
					p_q   <= '0;
					s_q   <= s_q + 1'b1;
					// every entry has been written by now
					len_q <= (AW + 1)'(ROW_LEN);
				end else begin
					p_q <= p_q + 1'b1;
				end
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	// butterfly addresses: insert a zero at bit s of the pair index
	logic [AW-1:0] pe;
	logic [AW-1:0] low_mask;
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;

	assign pe       = AW'(p_q);
	assign low_mask = (AW'(1) << s_q) - AW'(1);
	assign addr_a   = ((pe & ~low_mask) << 1) | (pe & low_mask);
	assign addr_b   = addr_a | (low_mask + AW'(1));

	// row memory
	logic [WW-1:0] mem [ROW_LEN];
	logic [WW-1:0] rd_a_s1;
	logic [WW-1:0] rd_b_s1;
	logic          mask_a_s1;
	logic          mask_b_s1;
	logic [AW-1:0] ra;
	logic [AW-1:0] wa;
	logic [WW-1:0] wd;
	logic          we;
	logic [WW-1:0] eff_a;
	logic [WW-1:0] eff_b;
	logic [WW-1:0] diff_q;

	assign ra = cmd.xf_rd ? addr_a : idx_q;

	always_comb begin
		we = 1'b0;
		wa = fill_q;
		wd = {{(WW - kvhq_pkg::SAMPLE_W){sample[kvhq_pkg::SAMPLE_W-1]}}, sample};
		if (cmd.load_wr) begin
			we = 1'b1;
		end else if (cmd.xf_wa) begin
			we = 1'b1;
			wa = addr_a;
			wd = eff_a + eff_b;
		end else if (cmd.xf_wb) begin
			we = 1'b1;
			wa = addr_b;
			wd = diff_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_s1 <= mem[ra];
		rd_b_s1 <= mem[addr_b];
	end

	// positions past the end of a short row read as zero
	always_ff @(posedge clk) begin
		mask_a_s1 <= {1'b0, ra} >= len_q;
		mask_b_s1 <= {1'b0, addr_b} >= len_q;
		if (cmd.xf_wa) begin
			diff_q <= eff_a - eff_b;
		end
	end

	assign eff_a = mask_a_s1 ? '0 : rd_a_s1;
	assign eff_b = mask_b_s1 ? '0 : rd_b_s1;

	// magnitude and row maximum
	logic [WW-1:0] mag_a;
	logic [WW-1:0] mx_q;
	logic          mx_zero;

	assign mag_a   = eff_a[WW-1] ? (~eff_a + 1'b1) : eff_a;
	assign mx_zero = mx_q == '0;

	always_ff @(posedge clk) begin
		if (cmd.close) begin
			mx_q <= '0;
		end else if (cmd.max_acc && (mag_a > mx_q)) begin
			mx_q <= mag_a;
		end
	end

	// divider operands
	logic [DVW-1:0] scl_dvd;
	logic [DVW-1:0] el_dvd;
	logic           div_start;
	logic [RW-1:0]  div_rem;
	logic [DVW-1:0] div_bits;
	logic [RW-1:0]  div_dsr;
	logic [CW-1:0]  div_steps;
	logic           div_busy;
	logic [DVW-1:0] quot;

	assign scl_dvd = (DVW'(mx_q) << 9) | DVW'(qmax);
	assign el_dvd  = ((DVW'(mag_a) * DVW'(qmax)) << 1) + DVW'(mx_q);

	assign div_start = cmd.scale_start || cmd.el_start;

	always_comb begin
		if (cmd.scale_start) begin
			div_rem   = '0;
			div_bits  = scl_dvd;
			div_dsr   = RW'({qmax, 1'b0});
			div_steps = CW'(DVW);
		end else begin
			// quotient is below 8: start from the dividend shifted down by three
			div_rem   = RW'(el_dvd >> 3);
			div_bits  = el_dvd << (DVW - 3);
			div_dsr   = RW'({mx_q, 1'b0});
			div_steps = CW'(3);
		end
	end

	kvhq_div #(
		.DVW(DVW),
		.RW (RW),
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.bits_init(div_bits),
		.divisor  (div_dsr),
		.steps    (div_steps),
		.busy     (div_busy),
		.quot     (quot)
	);

	// scale and codes
	logic [kvhq_pkg::SCALE_W-1:0] scale_q;
	logic                         neg_q;
	logic [QW-1:0]                q_raw;
	logic [QW-1:0]                q_val;
	logic [kvhq_pkg::CODE_W-1:0]  code_d;

	always_ff @(posedge clk) begin
		if (cmd.scale_take) begin
			if (mx_zero) begin
				scale_q <= kvhq_pkg::SCALE_ONE;
			end else if (|quot[DVW-1:kvhq_pkg::SCALE_W]) begin
				scale_q <= kvhq_pkg::SCALE_SAT;
			end else begin
				scale_q <= quot[kvhq_pkg::SCALE_W-1:0];
			end
		end
		if (cmd.el_start) begin
			neg_q <= eff_a[WW-1];
		end
	end

	assign q_raw  = mx_zero ? '0 : quot[QW-1:0];
	assign q_val  = (q_raw > qmax) ? qmax : q_raw;
	assign code_d = neg_q ? ({1'b0, qmax} - {1'b0, q_val}) : ({1'b0, qmax} + {1'b0, q_val});

	// output register
	logic                         out_valid_q;
	logic [kvhq_pkg::CODE_W-1:0]  code_q;
	logic [kvhq_pkg::SCALE_W-1:0] row_scale_q;
	logic                         last_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			code_q      <= code_d;
			row_scale_q <= scale_q;
			last_code_q <= idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign code      = code_q;
	assign row_scale = row_scale_q;
	assign last_code = last_code_q;

	assign sts.row_close = row_close;
	assign sts.quant_en  = quant_q;
	assign sts.xf_en     = rotate_q && POW2;
	assign sts.xf_last   = p_last && s_last;
	assign sts.idx_last  = idx_last;
	assign sts.div_busy  = div_busy;
	assign sts.out_free  = !out_valid_q || out_ready;

	`KVHQ_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_q || out_ready, "pending code overwritten")
	`KVHQ_ASSERT_NOW(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")
	`KVHQ_ASSERT_NEXT(a_code_range, cmd.out_load, code_q <= {qmax, 1'b0}, "code above 2*qmax")
	`KVHQ_ASSERT_NOW(a_xf_order, cmd.xf_wa, $past(cmd.xf_rd), "butterfly write without read")

endmodule

// File: design/kv_value_hadamard_quantizer.sv
// Hadamard-rotated absmax value quantizer. Samples of a token row are taken one per
// cycle; the row closes on row_end or on its HEADS*HEAD_DIM-th sample. With
// quantization enabled the block then runs, over the single row memory: an optional
// per-head Walsh-Hadamard transform (each butterfly reads a pair, then writes the sum
// and the difference), a max search that reads each element in turn, a bit-serial
// scale division, and per emitted code a memory read plus a 3-step division. New
// samples are not taken until the last code is in the output register; that register
// lets the next row load while the final code waits. Rows closed with quantization
// off emit nothing, and the block stays ready for samples of the next row.
module kv_value_hadamard_quantizer #(
	parameter int unsigned HEADS    = kvhq_pkg::HEADS_DEF,
	parameter int unsigned HEAD_DIM = kvhq_pkg::HEAD_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kvhq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kvhq_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [kvhq_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 row_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [kvhq_pkg::CODE_W-1:0]          code,
	output logic [kvhq_pkg::SCALE_W-1:0]         row_scale,
	output logic                                 last_code
);

	kvhq_pkg::kvhq_cmd_t cmd;
	kvhq_pkg::kvhq_sts_t sts;

	assign cfg_ready = 1'b1;

	kvhq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.sts     (sts),
		.cmd     (cmd),
		.in_ready(in_ready)
	);

	kvhq_dp #(
		.HEADS   (HEADS),
		.HEAD_DIM(HEAD_DIM)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample),
		.row_end  (row_end),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.code     (code),
		.row_scale(row_scale),
		.last_code(last_code)
	);

endmodule
